@@ design/tiled_density_scatter_accumulate_macros.svh @@
// Assertion macros for the density scatter-accumulate checker.
`ifndef TILED_DENSITY_SCATTER_ACCUMULATE_MACROS_SVH
`define TILED_DENSITY_SCATTER_ACCUMULATE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TDSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define TDSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/tdsa_pkg.sv @@
// Package: sizes, codes and register types of the density scatter-accumulate.
`default_nettype none

package tdsa_pkg;

  localparam int MAP_ENTRIES = 1024;
  localparam int SLOTS       = 16;
  localparam int TILE_EDGE   = 32;

  localparam int COORD_W     = 16;
  localparam int AREA_W      = 32;
  localparam int TILES_W     = 11;
  localparam int SLOTCNT_W   = 5;
  localparam int MAPSLOT_W   = 16;
  localparam int MAPIDX_IN_W = 10;
  localparam int RSLOT_IN_W  = 4;
  localparam int RCELL_IN_W  = 10;

  localparam int EDGE_W      = $clog2(TILE_EDGE);
  localparam int CELLS       = TILE_EDGE * TILE_EDGE;
  localparam int CELL_W      = 2 * EDGE_W;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOTAL_CELLS = SLOTS * CELLS;
  localparam int CELL_AW     = $clog2(TOTAL_CELLS);
  localparam int MAP_AW      = $clog2(MAP_ENTRIES);
  localparam int TX_W        = COORD_W - EDGE_W;
  localparam int PROD_W      = TX_W + TILES_W;
  localparam int IDX_W       = PROD_W + 1;

  localparam int PDATA_W     = 32;
  localparam int PADDR_W     = 3;
  localparam int REG_IDX_W   = 1;

  typedef enum logic [1:0] {
    REQ_MAP_WRITE  = 2'd0,
    REQ_ACCUMULATE = 2'd1,
    REQ_READ_CLEAR = 2'd2,
    REQ_UNUSED     = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_ZERO_AREA    = 2'd1,
    ST_NOT_OWNED    = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TILES_ACROSS = 1'b0,
    REG_SLOT_COUNT   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [TILES_W-1:0]   tiles_across;
    logic [SLOTCNT_W-1:0] slot_count;
  } cfg_t;

endpackage

`default_nettype wire

@@ design/tdsa_if.sv @@
// Channel interfaces: request items in, result items out.
`default_nettype none

interface tdsa_req_if
  import tdsa_pkg::*;
  (input wire logic clk);
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic [MAPIDX_IN_W-1:0] map_index;
  logic [MAPSLOT_W-1:0]   map_slot;
  logic [COORD_W-1:0]     coord_x;
  logic [COORD_W-1:0]     coord_y;
  logic signed [AREA_W-1:0] area;
  logic [RSLOT_IN_W-1:0]  read_slot;
  logic [RCELL_IN_W-1:0]  read_cell;

  modport source (input clk, ready, output valid, req_type, map_index, map_slot,
                  coord_x, coord_y, area, read_slot, read_cell);
  modport sink   (input clk, valid, req_type, map_index, map_slot, coord_x, coord_y,
                  area, read_slot, read_cell, output ready);
endinterface

interface tdsa_res_if
  import tdsa_pkg::*;
  (input wire logic clk);
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [AREA_W-1:0] read_value;

  modport source (input clk, ready, output valid, status, read_value);
  modport sink   (input clk, valid, status, read_value, output ready);
endinterface

`default_nettype wire

@@ design/tdsa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module tdsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/tdsa_cfg.sv @@
// APB-style register block: tiles_across and slot_count.
`default_nettype none

module tdsa_cfg
  import tdsa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tiles_across <= TILES_W'(1);
      cfg.slot_count   <= SLOTCNT_W'(16);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TILES_ACROSS: cfg.tiles_across <= pwdata[TILES_W-1:0];
        REG_SLOT_COUNT:   cfg.slot_count   <= pwdata[SLOTCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TILES_ACROSS: prdata = PDATA_W'(cfg.tiles_across);
      REG_SLOT_COUNT:   prdata = PDATA_W'(cfg.slot_count);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/tiled_density_scatter_accumulate.sv @@
// Top level: tiled density scatter-accumulate engine around two RAMs.
//
// Usage
//   req (valid/ready): one item per request. req_type selects a tile map
//   write, an accumulate of a signed Q16.16 area, or a read-and-clear of one
//   cell. res (valid/ready): exactly one result item per request, in order,
//   carrying status and, for a successful read, the cell value.
//   APB port: tiles_across at 0x0, slot_count at 0x4; write only while idle.
// Steps (accept to res.valid)
//   map write, read-clear, unused type, zero area: final step only.
//   accumulate: multiply, index add and map RAM read, owner check
//   and cell RAM read, saturating add and write back; an out-of-range index
//   or an unowned tile goes straight on to the final step.
// Flow
//   One item at a time through the engine: a new item is taken only once
//   the last has left its final step. The result register lets the engine
//   take the next item while a result waits; if the sink stalls the engine
//   holds in its final step.
// Reset
//   rst (sync) clears control state and starts a clearing pass that zeroes
//   all 16384 accumulator cells, one per cycle; req.ready stays low until
//   the pass ends. The tile map is not cleared and must be written before use.
`default_nettype none

module tiled_density_scatter_accumulate
  import tdsa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  tdsa_req_if.sink                req,
  tdsa_res_if.source              res,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  // Engine steps
  typedef enum logic [2:0] {
    S_CLEAR,  // zeroing the accumulators after reset
    S_IDLE,   // ready for an item
    S_MUL,    // tile_x * tiles_across
    S_IDX,    // index add, range check, map read
    S_SLOT,   // owner check, cell read
    S_FIN     // write back and hand result over
  } state_t;

  // What the final step does
  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_MAP,
    FIN_ACC,
    FIN_READ
  } fin_op_t;

  cfg_t cfg;

  tdsa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t                   state;
  fin_op_t                  fin_op;
  status_t                  fin_status;
  logic [CELL_AW-1:0]       clr_addr;
  logic [CELL_AW-1:0]       cell_addr;
  logic [COORD_W-1:0]       r_x;
  logic [COORD_W-1:0]       r_y;
  logic signed [AREA_W-1:0] r_area;
  logic [MAP_AW-1:0]        r_map_addr;
  logic [MAPSLOT_W-1:0]     r_map_slot;
  logic [PROD_W-1:0]        prod;

  logic                     out_valid;
  status_t                  out_status;
  logic signed [AREA_W-1:0] out_value;

  // RAM ports
  logic                     map_we;
  logic                     map_re;
  logic [MAP_AW-1:0]        map_raddr;
  logic [MAPSLOT_W-1:0]     map_rdata;
  logic                     acc_we;
  logic [CELL_AW-1:0]       acc_waddr;
  logic [AREA_W-1:0]        acc_wdata;
  logic                     acc_re;
  logic [CELL_AW-1:0]       acc_raddr;
  logic [AREA_W-1:0]        acc_rdata;

  logic                     accept;
  logic                     fin_go;
  logic [IDX_W-1:0]         midx;
  logic                     idx_bad;
  logic                     slot_bad;
  logic [CELL_AW-1:0]       rd_cell_addr;
  logic [CELL_AW-1:0]       acc_cell_addr;
  logic                     rd_slot_bad;
  logic                     rd_cell_bad;
  logic signed [AREA_W:0]   sum;
  logic [AREA_W-1:0]        sat_sum;
  fin_op_t                  dec_op;
  status_t                  dec_status;
  state_t                   dec_state;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign fin_go     = (state == S_FIN) && (!out_valid || res.ready);

  assign res.valid      = out_valid;
  assign res.status     = out_status;
  assign res.read_value = out_value;

  // Map index: (x / edge) * tiles_across + (y / edge)
  assign midx    = IDX_W'(prod) + IDX_W'(r_y[COORD_W-1:EDGE_W]);
  assign idx_bad = (midx >= IDX_W'(MAP_ENTRIES));

  // Owner check on the mapped slot
  assign slot_bad = (map_rdata >= MAPSLOT_W'(cfg.slot_count)) ||
                    (map_rdata >= MAPSLOT_W'(SLOTS));
  assign acc_cell_addr = CELL_AW'({map_rdata[SLOT_W-1:0],
                                   r_x[EDGE_W-1:0], r_y[EDGE_W-1:0]});

  // Read-clear address and checks, straight from the request
  assign rd_slot_bad  = (32'(req.read_slot) >= 32'(SLOTS));
  assign rd_cell_bad  = (32'(req.read_cell) >= 32'(CELLS));
  assign rd_cell_addr = CELL_AW'({req.read_slot[SLOT_W-1:0],
                                  req.read_cell[CELL_W-1:0]});

  // Decode of the offered item, taken on acceptance
  always_comb begin
    dec_op     = FIN_NONE;
    dec_status = ST_DONE;
    dec_state  = S_FIN;
    case (req.req_type)
      REQ_MAP_WRITE: begin
        if (32'(req.map_index) >= 32'(MAP_ENTRIES)) begin
          dec_status = ST_OUT_OF_RANGE;
        end else begin
          dec_op = FIN_MAP;
        end
      end
      REQ_ACCUMULATE: begin
        if (req.area == '0) begin
          dec_status = ST_ZERO_AREA;
        end else begin
          dec_state = S_MUL;
        end
      end
      REQ_READ_CLEAR: begin
        if (rd_slot_bad) begin
          dec_status = ST_NOT_OWNED;
        end else if (rd_cell_bad) begin
          dec_status = ST_OUT_OF_RANGE;
        end else begin
          dec_op = FIN_READ;
        end
      end
      default: ;
    endcase
  end

  // Saturating add of the stored cell and the area
  assign sum = {acc_rdata[AREA_W-1], acc_rdata} + {r_area[AREA_W-1], r_area};
  always_comb begin
    if (sum[AREA_W] != sum[AREA_W-1]) begin
      sat_sum = sum[AREA_W] ? {1'b1, {(AREA_W-1){1'b0}}} : {1'b0, {(AREA_W-1){1'b1}}};
    end else begin
      sat_sum = sum[AREA_W-1:0];
    end
  end

  // RAM controls
  always_comb begin
    map_we    = fin_go && (fin_op == FIN_MAP);
    map_re    = (state == S_IDX) && !idx_bad;
    map_raddr = midx[MAP_AW-1:0];

    acc_re    = 1'b0;
    acc_raddr = acc_cell_addr;
    if (state == S_SLOT && !slot_bad) begin
      acc_re = 1'b1;
    end else if (accept && req.req_type == REQ_READ_CLEAR && !rd_slot_bad && !rd_cell_bad) begin
      acc_re    = 1'b1;
      acc_raddr = rd_cell_addr;
    end

    if (state == S_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_addr;
      acc_wdata = '0;
    end else begin
      acc_we    = fin_go && (fin_op == FIN_ACC || fin_op == FIN_READ);
      acc_waddr = cell_addr;
      acc_wdata = (fin_op == FIN_ACC) ? sat_sum : '0;
    end
  end

  tdsa_ram #(.WIDTH(MAPSLOT_W), .DEPTH(MAP_ENTRIES)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (r_map_addr),
    .wdata (r_map_slot),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  tdsa_ram #(.WIDTH(AREA_W), .DEPTH(TOTAL_CELLS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // Engine sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + CELL_AW'(1);
          if (clr_addr == CELL_AW'(TOTAL_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            r_x        <= req.coord_x;
            r_y        <= req.coord_y;
            r_area     <= req.area;
            r_map_addr <= req.map_index[MAP_AW-1:0];
            r_map_slot <= req.map_slot;
            cell_addr  <= rd_cell_addr;
            fin_op     <= dec_op;
            fin_status <= dec_status;
            state      <= dec_state;
          end
        end

        S_MUL: begin
          prod  <= PROD_W'(r_x[COORD_W-1:EDGE_W]) * PROD_W'(cfg.tiles_across);
          state <= S_IDX;
        end

        S_IDX: begin
          if (idx_bad) begin
            fin_status <= ST_OUT_OF_RANGE;
            state      <= S_FIN;
          end else begin
            state <= S_SLOT;
          end
        end

        S_SLOT: begin
          if (slot_bad) begin
            fin_status <= ST_NOT_OWNED;
          end else begin
            fin_op    <= FIN_ACC;
            cell_addr <= acc_cell_addr;
          end
          state <= S_FIN;
        end

        S_FIN: begin
          if (fin_go) begin
            out_status <= fin_status;
            out_value  <= (fin_op == FIN_READ) ? acc_rdata : '0;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/tdsa_checker.sv @@
// Port-level checker for the density scatter-accumulate, bound to the top level.
`default_nettype none
`include "tiled_density_scatter_accumulate_macros.svh"

module tdsa_checker
  import tdsa_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire logic [1:0]        res_status,
  input wire logic [AREA_W-1:0] res_read_value
);

  logic       req_acc;
  logic       res_acc;
  logic [1:0] pending;

  assign req_acc = req_valid && req_ready;
  assign res_acc = res_valid && res_ready;

  // Items taken but whose result has not gone yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_acc) - 2'(res_acc);
    end
  end

  `TDSA_ASSERT_IMPL(a_no_orphan_result, clk, rst, res_valid, pending != 2'd0, "result without item")
  `TDSA_ASSERT_IMPL(a_two_in_flight, clk, rst, req_acc, pending != 2'd2, "third item taken")
  `TDSA_ASSERT_IMPL(a_value_only_done, clk, rst, res_valid && res_read_value != '0, res_status == ST_DONE, "value on failed item")
  `TDSA_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_read_value), "stalled result changed")

endmodule

bind tiled_density_scatter_accumulate tdsa_checker u_tdsa_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_status     (res.status),
  .res_read_value (res.read_value)
);

`default_nettype wire
